>>> hw/rtl/pac_pkg.sv
// Shared types, codes and helper functions of the pileup allele classifier.
`default_nettype none

package pac_pkg;

    // Default width of query-side counters.
    localparam int POSITION_BITS_DEF = 32;
    // Longest insertion whose bases are compared.
    localparam int MAX_INSERT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR_POSITION   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_LENGTH        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_LENGTH        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_FIRST_BASE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_FIRST_BASE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INSERT_CHARS_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_INSERT_CHARS_HIGH = 3'd6;

    // CIGAR operation codes.
    localparam logic [3:0] CIG_M  = 4'd0;
    localparam logic [3:0] CIG_I  = 4'd1;
    localparam logic [3:0] CIG_D  = 4'd2;
    localparam logic [3:0] CIG_N  = 4'd3;
    localparam logic [3:0] CIG_S  = 4'd4;
    localparam logic [3:0] CIG_H  = 4'd5;
    localparam logic [3:0] CIG_P  = 4'd6;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X  = 4'd8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_CIGAR = 2'd1,
        OP_BASE  = 2'd2,
        OP_END   = 2'd3
    } pac_op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CIGAR = 2'd1,
        PH_BASES = 2'd2
    } pac_phase_t;

    typedef enum logic [1:0] {
        ALLELE_NONE  = 2'd0,
        ALLELE_REF   = 2'd1,
        ALLELE_ALT   = 2'd2,
        ALLELE_UNDEF = 2'd3
    } pac_allele_t;

    typedef struct packed {
        logic [30:0]  anchor_position;
        logic [7:0]   ref_length;
        logic [7:0]   alt_length;
        logic [7:0]   ref_first_base;
        logic [7:0]   alt_first_base;
        logic [127:0] insert_chars;   // suffix char j in bits 8j+7..8j
    } pac_cfg_t;

    // One-cycle strobes of the item being applied to the read state.
    typedef struct packed {
        logic start;
        logic cigar;
        logic base;
    } pac_step_t;

    typedef struct packed {
        logic anchor_found;
        logic walk_aborted;
    } pac_walk_t;

    typedef struct packed {
        logic        anchor_mapped;
        logic        detail_eligible;
        pac_allele_t allele;
    } pac_result_t;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] comp_base(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "A":     r = "T";
            "C":     r = "G";
            "G":     r = "C";
            "T":     r = "A";
            "a":     r = "t";
            "c":     r = "g";
            "g":     r = "c";
            "t":     r = "a";
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pac_walk.sv
// CIGAR walk: locates the anchor's query index and the indel that follows it.
`default_nettype none

module pac_walk #(
    parameter int POSITION_BITS = pac_pkg::POSITION_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  pac_pkg::pac_step_t       step,
    input  wire [30:0]               anchor_position,
    input  wire [31:0]               alignment_start,
    input  wire [3:0]                cigar_code,
    input  wire [27:0]               cigar_length,
    output pac_pkg::pac_walk_t       walk,
    output logic [POSITION_BITS-1:0] anchor_query_index,
    output logic signed [28:0]       indel_after_anchor
);
    import pac_pkg::*;

    localparam int QSW = (POSITION_BITS > 28 ? POSITION_BITS : 28) + 1;
    localparam int ASW = (POSITION_BITS > 31 ? POSITION_BITS : 31) + 1;

    logic                     found_reg, found_next;
    logic                     aborted_reg, aborted_next;
    logic                     awaiting_reg, awaiting_next;
    logic [32:0]              ref_cur_reg, ref_cur_next;
    logic [POSITION_BITS-1:0] query_cur_reg, query_cur_next;
    logic [POSITION_BITS-1:0] aqi_reg, aqi_next;
    logic signed [28:0]       indel_reg, indel_next;

    logic                     bad, aligned, del_skip, in_range, last_base;
    logic [33:0]              anchor_ext, ref_end;
    logic [30:0]              offset;
    logic [QSW-1:0]           q_sum;
    logic [ASW-1:0]           a_sum;
    logic [POSITION_BITS-1:0] q_sat, a_sat;
    logic signed [28:0]       len_s;

    always_comb begin
        bad        = (cigar_length == 28'd0) || (cigar_code > CIG_X);
        aligned    = (cigar_code == CIG_M) || (cigar_code == CIG_EQ) || (cigar_code == CIG_X);
        del_skip   = (cigar_code == CIG_D) || (cigar_code == CIG_N);
        anchor_ext = {3'b000, anchor_position};
        ref_end    = {1'b0, ref_cur_reg} + {6'd0, cigar_length};
        in_range   = (anchor_ext >= {1'b0, ref_cur_reg}) && (anchor_ext < ref_end);
        last_base  = (anchor_ext == ref_end - 34'd1);
        offset     = anchor_position - ref_cur_reg[30:0];
        q_sum      = QSW'(query_cur_reg) + QSW'(cigar_length);
        a_sum      = ASW'(query_cur_reg) + ASW'(offset);
        q_sat      = (q_sum[QSW-1:POSITION_BITS] != '0) ? '1 : q_sum[POSITION_BITS-1:0];
        a_sat      = (a_sum[ASW-1:POSITION_BITS] != '0) ? '1 : a_sum[POSITION_BITS-1:0];
        len_s      = $signed({1'b0, cigar_length});

        found_next     = found_reg;
        aborted_next   = aborted_reg;
        awaiting_next  = awaiting_reg;
        ref_cur_next   = ref_cur_reg;
        query_cur_next = query_cur_reg;
        aqi_next       = aqi_reg;
        indel_next     = indel_reg;

        if (step.start) begin
            found_next     = 1'b0;
            aborted_next   = alignment_start[31] || ({1'b0, anchor_position} < alignment_start);
            awaiting_next  = 1'b0;
            ref_cur_next   = {2'b00, alignment_start[30:0]};
            query_cur_next = '0;
            aqi_next       = '0;
            indel_next     = '0;
        end else if (step.base) begin
            awaiting_next = 1'b0;
        end else if (step.cigar && !aborted_reg) begin
            if (awaiting_reg) begin
                // the op right after the anchor's final base
                awaiting_next = 1'b0;
                if (bad) begin
                    aborted_next = 1'b1;
                    found_next   = 1'b0;
                    indel_next   = '0;
                end else if (cigar_code == CIG_I) begin
                    indel_next = len_s;
                end else if (cigar_code == CIG_D) begin
                    indel_next = -len_s;
                end
            end else if (!found_reg) begin
                if (bad) begin
                    aborted_next = 1'b1;
                end else if (aligned && in_range) begin
                    found_next    = 1'b1;
                    aqi_next      = a_sat;
                    awaiting_next = last_base;
                end else if (del_skip && in_range) begin
                    aborted_next = 1'b1;
                end else begin
                    if (aligned || del_skip) begin
                        ref_cur_next = ref_end[33] ? '1 : ref_end[32:0];
                    end
                    if (aligned || cigar_code == CIG_I || cigar_code == CIG_S) begin
                        query_cur_next = q_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg    <= 1'b0;
            aborted_reg  <= 1'b0;
            awaiting_reg <= 1'b0;
        end else begin
            found_reg    <= found_next;
            aborted_reg  <= aborted_next;
            awaiting_reg <= awaiting_next;
        end
    end

    always_ff @(posedge aclk) begin
        ref_cur_reg   <= ref_cur_next;
        query_cur_reg <= query_cur_next;
        aqi_reg       <= aqi_next;
        indel_reg     <= indel_next;
    end

    assign walk.anchor_found  = found_reg;
    assign walk.walk_aborted  = aborted_reg;
    assign anchor_query_index = aqi_reg;
    assign indel_after_anchor = indel_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pac_bases.sv
// Base capture: counts bases, grabs the anchor base, checks insertion bases.
`default_nettype none

module pac_bases #(
    parameter int POSITION_BITS = pac_pkg::POSITION_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  pac_pkg::pac_step_t       step,
    input  pac_pkg::pac_cfg_t        cfg,
    input  pac_pkg::pac_walk_t       walk,
    input  wire [POSITION_BITS-1:0]  anchor_query_index,
    input  wire                      reverse_strand,
    input  wire [7:0]                query_base,
    output logic [POSITION_BITS-1:0] base_counter,
    output logic [7:0]               anchor_char,
    output logic                     insert_mismatch
);
    import pac_pkg::*;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [7:0]               char_reg, char_next;
    logic                     mismatch_reg, mismatch_next;
    logic                     strand_reg, strand_next;

    logic [7:0]               ins;
    logic [POSITION_BITS-1:0] ins_pos, ins_pos_m1;
    logic [3:0]               k, idx;
    logic [7:0]               idx_wide, got, want;
    logic                     check;

    always_comb begin
        ins        = cfg.alt_length - cfg.ref_length;
        ins_pos    = count_reg - anchor_query_index;
        ins_pos_m1 = ins_pos - POSITION_BITS'(1);
        k          = ins_pos_m1[3:0];
        idx_wide   = ins - 8'd1 - {4'd0, k};
        idx        = strand_reg ? idx_wide[3:0] : k;
        got        = strand_reg ? comp_base(query_base) : query_base;
        want       = cfg.insert_chars[{idx, 3'b000} +: 8];
        check      = walk.anchor_found && (cfg.ref_length != 8'd0)
                     && (cfg.alt_length > cfg.ref_length)
                     && (ins <= 8'(MAX_INSERT))
                     && (count_reg > anchor_query_index)
                     && (ins_pos <= POSITION_BITS'(ins));

        count_next    = count_reg;
        char_next     = char_reg;
        mismatch_next = mismatch_reg;
        strand_next   = strand_reg;

        if (step.start) begin
            count_next    = '0;
            char_next     = 8'd0;
            mismatch_next = 1'b0;
            strand_next   = reverse_strand;
        end else if (step.base) begin
            if (walk.anchor_found && count_reg == anchor_query_index) begin
                char_next = query_base;
            end
            if (check && got != want) begin
                mismatch_next = 1'b1;
            end
            if (count_reg != '1) begin
                count_next = count_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mismatch_reg <= 1'b0;
            strand_reg   <= 1'b0;
        end else begin
            mismatch_reg <= mismatch_next;
            strand_reg   <= strand_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        char_reg  <= char_next;
    end

    assign base_counter    = count_reg;
    assign anchor_char     = char_reg;
    assign insert_mismatch = mismatch_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pac_classify.sv
// End-of-read classification of the collected read state.
`default_nettype none

module pac_classify #(
    parameter int POSITION_BITS = pac_pkg::POSITION_BITS_DEF
) (
    input  pac_pkg::pac_cfg_t       cfg,
    input  pac_pkg::pac_walk_t      walk,
    input  wire [POSITION_BITS-1:0] anchor_query_index,
    input  wire signed [28:0]       indel_after_anchor,
    input  wire [POSITION_BITS-1:0] base_counter,
    input  wire [7:0]               anchor_char,
    input  wire                     insert_mismatch,
    output pac_pkg::pac_result_t    result
);
    import pac_pkg::*;

    logic               mapped, eligible, short_read;
    logic [7:0]         ab, rf, af, ins, del;
    logic signed [28:0] ins_s, del_s;
    pac_allele_t        allele;

    always_comb begin
        mapped = walk.anchor_found && !walk.walk_aborted
                 && (anchor_query_index < base_counter);
        ab       = up_case(anchor_char);
        rf       = up_case(cfg.ref_first_base);
        af       = up_case(cfg.alt_first_base);
        eligible = (ab == rf) || (ab == af);
        ins      = cfg.alt_length - cfg.ref_length;
        del      = cfg.ref_length - cfg.alt_length;
        ins_s    = $signed({21'd0, ins});
        del_s    = $signed({21'd0, del});
        short_read = ((POSITION_BITS+1)'(anchor_query_index) + (POSITION_BITS+1)'(ins)
                      + (POSITION_BITS+1)'(1)) > (POSITION_BITS+1)'(base_counter);

        if (cfg.ref_length == 8'd1 && cfg.alt_length == 8'd1) begin
            allele = (ab == rf) ? ALLELE_REF : (ab == af) ? ALLELE_ALT : ALLELE_UNDEF;
        end else if (cfg.alt_length > cfg.ref_length) begin
            if (indel_after_anchor == ins_s) begin
                if (short_read || ins > 8'(MAX_INSERT) || insert_mismatch) begin
                    allele = ALLELE_UNDEF;
                end else begin
                    allele = ALLELE_ALT;
                end
            end else begin
                allele = (indel_after_anchor == 29'sd0) ? ALLELE_REF : ALLELE_UNDEF;
            end
        end else if (cfg.ref_length > cfg.alt_length) begin
            if (indel_after_anchor == -del_s) begin
                allele = ALLELE_ALT;
            end else begin
                allele = (indel_after_anchor == 29'sd0) ? ALLELE_REF : ALLELE_UNDEF;
            end
        end else begin
            allele = ALLELE_UNDEF;
        end

        result.anchor_mapped = mapped;
        if (!mapped || cfg.ref_length == 8'd0 || cfg.alt_length == 8'd0) begin
            result.allele          = ALLELE_NONE;
            result.detail_eligible = 1'b0;
        end else begin
            result.allele          = allele;
            result.detail_eligible = eligible;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pileup_allele_classifier.sv
// Top level of the pileup allele classifier: channels, read phase, result register.
//
// Usage: stream each read as a start beat, its CIGAR operation beats, its
// base beats and an end beat. s_tuser carries the beat kind (0 start,
// 1 CIGAR op, 2 base, 3 end); s_tdata carries the payload fields. Each read
// gives exactly one result beat on m_tdata, triggered by its end beat;
// beats outside a read give nothing.
// Path: an end beat accepted into the input register goes through the
// walk, base and classification logic in one pass into the result
// register, which drives m_tvalid.
// Throughput: one beat per cycle while no end beat waits (see Stall), set
// by the single pass from input register into read state and result register.
// Stall: while m_tvalid is high and m_tready low, the result holds; beats
// that make no result keep flowing, and an end beat waits in the input
// register, which drops s_tready until the result register frees.
// Reset (aresetn low, synchronous): channels empty, read phase idle, all
// configuration registers back to their defaults (anchor 0, lengths 1,
// first bases 'A', insertion characters zero). Write configuration through
// cfg_we/cfg_index/cfg_data only while no read is in flight.
`default_nettype none

module pileup_allele_classifier #(
    parameter int POSITION_BITS = pac_pkg::POSITION_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration write port
    input  wire                             cfg_we,
    input  wire [pac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [pac_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input beats
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // s_tdata: alignment_start[31:0], reverse_strand[32], cigar_code[36:33],
    //          cigar_length[64:37], query_base[72:65], zero pad[79:73]
    input  wire [pac_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation[1:0]
    input  wire [1:0]                       s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // m_tdata: allele[1:0], detail_eligible[2], anchor_mapped[3], zero pad[7:4]
    output logic [pac_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pac_pkg::*;

    // configuration registers
    pac_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.anchor_position <= 31'd0;
            cfg_reg.ref_length      <= 8'd1;
            cfg_reg.alt_length      <= 8'd1;
            cfg_reg.ref_first_base  <= "A";
            cfg_reg.alt_first_base  <= "A";
            cfg_reg.insert_chars    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ANCHOR_POSITION:   cfg_reg.anchor_position     <= cfg_data[30:0];
                CFG_REF_LENGTH:        cfg_reg.ref_length          <= cfg_data[7:0];
                CFG_ALT_LENGTH:        cfg_reg.alt_length          <= cfg_data[7:0];
                CFG_REF_FIRST_BASE:    cfg_reg.ref_first_base      <= cfg_data[7:0];
                CFG_ALT_FIRST_BASE:    cfg_reg.alt_first_base      <= cfg_data[7:0];
                CFG_INSERT_CHARS_LOW:  cfg_reg.insert_chars[63:0]   <= cfg_data;
                CFG_INSERT_CHARS_HIGH: cfg_reg.insert_chars[127:64] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic        in_valid_reg;
    pac_op_t     in_op_reg;
    logic [31:0] in_start_reg;
    logic        in_rev_reg;
    logic [3:0]  in_code_reg;
    logic [27:0] in_len_reg;
    logic [7:0]  in_base_reg;

    pac_phase_t  phase_reg, phase_next;
    logic        m_valid_reg;
    pac_result_t result_reg;
    pac_result_t result;

    logic        out_free, makes_result, advance, accept, emit;
    pac_step_t   step;

    always_comb begin
        out_free     = !m_valid_reg || m_tready;
        makes_result = (in_op_reg == OP_END) && (phase_reg != PH_IDLE);
        // hold an end beat until the result register can take it
        advance      = in_valid_reg && (!makes_result || out_free);
        accept       = s_tvalid && s_tready;
        emit         = advance && makes_result;

        step.start = advance && (in_op_reg == OP_START);
        step.cigar = advance && (in_op_reg == OP_CIGAR) && (phase_reg == PH_CIGAR);
        step.base  = advance && (in_op_reg == OP_BASE) && (phase_reg != PH_IDLE);

        phase_next = phase_reg;
        if (advance) begin
            case (in_op_reg)
                OP_START: phase_next = PH_CIGAR;
                OP_CIGAR: phase_next = phase_reg;
                OP_BASE:  phase_next = (phase_reg == PH_IDLE) ? PH_IDLE : PH_BASES;
                OP_END:   phase_next = PH_IDLE;
                default:  phase_next = phase_reg;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_op_reg    <= pac_op_t'(s_tuser);
            in_start_reg <= s_tdata[31:0];
            in_rev_reg   <= s_tdata[32];
            in_code_reg  <= s_tdata[36:33];
            in_len_reg   <= s_tdata[64:37];
            in_base_reg  <= s_tdata[72:65];
        end
        if (emit) begin
            result_reg <= result;
        end
    end

    // read state
    pac_walk_t                walk;
    logic [POSITION_BITS-1:0] anchor_query_index;
    logic signed [28:0]       indel_after_anchor;
    logic [POSITION_BITS-1:0] base_counter;
    logic [7:0]               anchor_char;
    logic                     insert_mismatch;

    pac_walk #(
        .POSITION_BITS(POSITION_BITS)
    ) u_walk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .step               (step),
        .anchor_position    (cfg_reg.anchor_position),
        .alignment_start    (in_start_reg),
        .cigar_code         (in_code_reg),
        .cigar_length       (in_len_reg),
        .walk               (walk),
        .anchor_query_index (anchor_query_index),
        .indel_after_anchor (indel_after_anchor)
    );

    pac_bases #(
        .POSITION_BITS(POSITION_BITS)
    ) u_bases (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .step               (step),
        .cfg                (cfg_reg),
        .walk               (walk),
        .anchor_query_index (anchor_query_index),
        .reverse_strand     (in_rev_reg),
        .query_base         (in_base_reg),
        .base_counter       (base_counter),
        .anchor_char        (anchor_char),
        .insert_mismatch    (insert_mismatch)
    );

    pac_classify #(
        .POSITION_BITS(POSITION_BITS)
    ) u_classify (
        .cfg                (cfg_reg),
        .walk               (walk),
        .anchor_query_index (anchor_query_index),
        .indel_after_anchor (indel_after_anchor),
        .base_counter       (base_counter),
        .anchor_char        (anchor_char),
        .insert_mismatch    (insert_mismatch),
        .result             (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, result_reg};

endmodule

`default_nettype wire

>>> tb/sv/allele_call_tb_pkg.sv
// Scoreboard for the pileup allele classifier: read-state predictor and expected calls.
package allele_call_tb_pkg;
    import pac_pkg::*;

    localparam longint unsigned REF_CURSOR_MAX = (64'd1 << 33) - 64'd1;
    localparam longint unsigned QUERY_MAX      = (64'd1 << 32) - 64'd1;

    function automatic bit [7:0] upper_char(bit [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic bit [7:0] comp_char(bit [7:0] c);
        case (c)
            "A": return "T";
            "C": return "G";
            "G": return "C";
            "T": return "A";
            "a": return "t";
            "c": return "g";
            "g": return "c";
            "t": return "a";
            default: return c;
        endcase
    endfunction

    class allele_call_scoreboard;
        // register copies
        bit [30:0]   anchor_pos;
        bit [7:0]    ref_len;
        bit [7:0]    alt_len;
        bit [7:0]    ref_first;
        bit [7:0]    alt_first;
        bit [127:0]  ins_chars;

        // per-read state
        pac_phase_t  read_state;
        bit [32:0]   ref_cursor;
        bit [31:0]   query_cursor;
        bit [31:0]   anchor_idx;
        bit [31:0]   base_count;
        bit          found;
        bit          aborted;
        bit          awaiting;
        bit          ins_mismatch;
        bit          reverse;
        int          indel;
        bit [7:0]    anchor_base;

        pac_result_t expected_calls[$];
        int          errors;

        function new();
            anchor_pos = '0;
            ref_len    = 8'd1;
            alt_len    = 8'd1;
            ref_first  = "A";
            alt_first  = "A";
            ins_chars  = '0;
            read_state = PH_IDLE;
            errors     = 0;
            clear_read();
        endfunction

        function int pending();
            return expected_calls.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, bit [63:0] v);
            case (idx)
                CFG_ANCHOR_POSITION:   anchor_pos = v[30:0];
                CFG_REF_LENGTH:        ref_len = v[7:0];
                CFG_ALT_LENGTH:        alt_len = v[7:0];
                CFG_REF_FIRST_BASE:    ref_first = v[7:0];
                CFG_ALT_FIRST_BASE:    alt_first = v[7:0];
                CFG_INSERT_CHARS_LOW:  ins_chars[63:0] = v;
                CFG_INSERT_CHARS_HIGH: ins_chars[127:64] = v;
                default: ;
            endcase
        endfunction

        function void clear_read();
            ref_cursor   = '0;
            query_cursor = '0;
            anchor_idx   = '0;
            base_count   = '0;
            found        = 1'b0;
            aborted      = 1'b0;
            awaiting     = 1'b0;
            ins_mismatch = 1'b0;
            reverse      = 1'b0;
            indel        = 0;
            anchor_base  = '0;
        endfunction

        function bit [31:0] sat_query(longint unsigned v);
            return (v > QUERY_MAX) ? '1 : v[31:0];
        endfunction

        function void drop_walk();
            aborted  = 1'b1;
            found    = 1'b0;
            awaiting = 1'b0;
            indel    = 0;
        endfunction

        // Advance the CIGAR walk by one operation.
        function void walk_cigar(bit [3:0] code, bit [27:0] len);
            bit              bad;
            bit              aligned;
            bit              in_rng;
            longint unsigned a;
            longint unsigned cur;
            longint unsigned rend;
            bad = (len == 0) || (code > CIG_X);
            a   = anchor_pos;
            cur = ref_cursor;
            if (aborted) return;
            if (awaiting) begin
                // operation right after the anchor's last base
                awaiting = 1'b0;
                if (bad) drop_walk();
                else if (code == CIG_I) indel = int'(len);
                else if (code == CIG_D) indel = -int'(len);
                return;
            end
            if (found) return;
            if (bad) begin
                drop_walk();
                return;
            end
            rend    = cur + longint'(len);
            aligned = (code == CIG_M) || (code == CIG_EQ) || (code == CIG_X);
            in_rng  = (a >= cur) && (a < rend);
            if (aligned && in_rng) begin
                found      = 1'b1;
                anchor_idx = sat_query(longint'(query_cursor) + (a - cur));
                if (a == rend - 1) awaiting = 1'b1;
                return;
            end
            if ((code == CIG_D || code == CIG_N) && in_rng) begin
                drop_walk();
                return;
            end
            if (aligned || code == CIG_D || code == CIG_N)
                ref_cursor = (rend > REF_CURSOR_MAX) ? REF_CURSOR_MAX[32:0] : rend[32:0];
            if (aligned || code == CIG_I || code == CIG_S)
                query_cursor = sat_query(longint'(query_cursor) + longint'(len));
        endfunction

        // Capture the anchor base and compare insertion bases with the suffix.
        function void take_base(bit [7:0] b);
            longint unsigned i;
            longint unsigned ai;
            longint unsigned span;
            longint unsigned k;
            longint unsigned sidx;
            int unsigned     j;
            bit [7:0]        got;
            i  = base_count;
            ai = anchor_idx;
            if (found && i == ai) anchor_base = b;
            if (found && ref_len >= 1 && alt_len > ref_len) begin
                span = alt_len - ref_len;
                if (span <= MAX_INSERT && i > ai && i <= ai + span) begin
                    k    = i - ai - 1;
                    got  = reverse ? comp_char(b) : b;
                    sidx = reverse ? span - 1 - k : k;
                    j    = sidx[3:0];
                    if (got != ins_chars[8*j +: 8]) ins_mismatch = 1'b1;
                end
            end
            base_count = sat_query(longint'(base_count) + 1);
        endfunction

        function pac_result_t call_allele();
            pac_result_t r;
            pac_allele_t al;
            bit          mapped;
            bit          elig;
            bit [7:0]    ab;
            bit [7:0]    rf;
            bit [7:0]    af;
            int          span;
            r      = '0;
            mapped = found && !aborted && (anchor_idx < base_count);
            r.anchor_mapped = mapped;
            if (!mapped || ref_len == 0 || alt_len == 0) return r;
            ab   = upper_char(anchor_base);
            rf   = upper_char(ref_first);
            af   = upper_char(alt_first);
            elig = (ab == rf) || (ab == af);
            if (ref_len == 1 && alt_len == 1) begin
                al = (ab == rf) ? ALLELE_REF : (ab == af) ? ALLELE_ALT : ALLELE_UNDEF;
            end else if (alt_len > ref_len) begin
                span = alt_len - ref_len;
                if (indel == span) begin
                    if (longint'(anchor_idx) + 1 + span > longint'(base_count))
                        al = ALLELE_UNDEF;
                    else if (span > MAX_INSERT)
                        al = ALLELE_UNDEF;
                    else
                        al = ins_mismatch ? ALLELE_UNDEF : ALLELE_ALT;
                end else begin
                    al = (indel == 0) ? ALLELE_REF : ALLELE_UNDEF;
                end
            end else if (ref_len > alt_len) begin
                span = ref_len - alt_len;
                al = (indel == -span) ? ALLELE_ALT : (indel == 0) ? ALLELE_REF : ALLELE_UNDEF;
            end else begin
                al = ALLELE_UNDEF;
            end
            r.allele          = al;
            r.detail_eligible = elig;
            return r;
        endfunction

        // Apply one accepted input beat to the predicted read state.
        function void note_beat(pac_op_t op, bit [S_TDATA_W-1:0] d);
            case (op)
                OP_START: begin
                    clear_read();
                    read_state = PH_CIGAR;
                    reverse    = d[32];
                    if (d[31] || {1'b0, anchor_pos} < d[31:0]) aborted = 1'b1;
                    ref_cursor = {2'b00, d[30:0]};
                end
                OP_CIGAR: begin
                    if (read_state == PH_CIGAR) walk_cigar(d[36:33], d[64:37]);
                end
                OP_BASE: begin
                    if (read_state != PH_IDLE) begin
                        read_state = PH_BASES;
                        awaiting   = 1'b0;
                        take_base(d[72:65]);
                    end
                end
                default: begin
                    if (read_state != PH_IDLE) begin
                        expected_calls = {expected_calls, call_allele()};
                        read_state = PH_IDLE;
                    end
                end
            endcase
        endfunction

        task report(string what);
            if (errors < 50) $display("[%0t] call mismatch: %s", $time, what);
            errors++;
        endtask

        task check_call(bit [M_TDATA_W-1:0] t);
            pac_result_t e;
            if (expected_calls.size() == 0) begin
                report($sformatf("call %h with none outstanding", t));
                return;
            end
            e = expected_calls.pop_front();
            if (t[1:0] != e.allele)
                report($sformatf("allele %0d, predicted %0d", t[1:0], e.allele));
            if (t[2] != e.detail_eligible)
                report($sformatf("detail_eligible %0b, predicted %0b", t[2], e.detail_eligible));
            if (t[3] != e.anchor_mapped)
                report($sformatf("anchor_mapped %0b, predicted %0b", t[3], e.anchor_mapped));
        endtask
    endclass

endpackage

>>> tb/sv/tb_pileup_allele_classifier.sv
// Testbench top: streams directed and random reads through the classifier and scores each call.
module tb_pileup_allele_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import pac_pkg::*;
    import allele_call_tb_pkg::*;

    localparam int READ_BEATS  = 1400;     // random input beats, spread over the phases
    localparam int NUM_PHASES  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off
    localparam int SETTLE      = 8;        // cycles past the last call before idling is trusted

    // code outside the supported CIGAR set
    localparam logic [3:0] CIG_BAD = 4'hF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    allele_call_scoreboard sb = new();

    idle_mode_t idle_mode     = IDLE_NONE;
    int         hold_requests = 0;
    int         holds_seen    = 0;
    int         hold_left     = 0;
    int         cycles        = 0;
    int         read_beats    = 0;

    // tb copies of the registers, used only to shape the reads
    bit [30:0]  cfg_anchor;
    bit [7:0]   cfg_ref_len;
    bit [7:0]   cfg_alt_len;
    bit [7:0]   cfg_ref_first;
    bit [7:0]   cfg_alt_first;
    bit [127:0] cfg_chars;

    pileup_allele_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[pileup_allele_classifier] ERROR");
            $finish;
        end
    end

    // Draw one idle decision for either side of the block.
    function automatic bit idle_draw(bit receiver);
        int unsigned r = $urandom_range(0, 99);
        case (idle_mode)
            IDLE_SENDER:   return !receiver && (r < 80);
            IDLE_RECEIVER: return receiver && (r < 80);
            IDLE_BOTH:     return r < 14;
            default:       return 1'b0;
        endcase
    endfunction

    // Result side: random stalls, plus a long hold-off on request so the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (holds_seen != hold_requests) begin
            holds_seen <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_draw(1'b1);
        end
    end

    // Score every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_call(m_tdata);
    end

    function automatic bit [S_TDATA_W-1:0] beat_data(bit [31:0] at, bit rev, bit [3:0] code,
                                                      bit [27:0] len, bit [7:0] b);
        return {7'b0, b, len, code, rev, at};
    endfunction

    function automatic bit [7:0] pick_base();
        string       nuc = "ACGT";
        int unsigned r   = $urandom_range(0, 99);
        bit [7:0]    c;
        c = nuc[$urandom_range(0, 3)];
        if (r < 10) c = c | 8'h20;
        else if (r < 20) c = 8'($urandom);
        return c;
    endfunction

    // Offer one beat, idling first as the phase asks; return once it is taken.
    task automatic send_beat(pac_op_t op, bit [S_TDATA_W-1:0] d);
        while (idle_draw(1'b0)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(op, d);
        read_beats++;
    endtask

    task automatic send_start(bit [31:0] at, bit rev);
        send_beat(OP_START, beat_data(at, rev, '0, '0, '0));
    endtask

    task automatic send_op(bit [3:0] code, bit [27:0] len);
        send_beat(OP_CIGAR, beat_data('0, 1'b0, code, len, '0));
    endtask

    task automatic send_base(bit [7:0] b);
        send_beat(OP_BASE, beat_data('0, 1'b0, '0, '0, b));
    endtask

    task automatic send_end();
        send_beat(OP_END, '0);
    endtask

    // Drop valid and wait until every call has come back and the pipe has drained.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One read shaped around the anchor: mostly well formed, with random content
    // and occasional breakage (unmapped starts, bad ops, short base runs, restarts).
    task automatic send_read();
        bit [7:0]    seq[$];
        bit          rev;
        bit [31:0]   at;
        int unsigned v;
        int unsigned off;
        int unsigned clip;
        int unsigned m1;
        int unsigned tail;
        int unsigned aidx;
        int unsigned qlen;
        int unsigned nb;
        int unsigned ilen;
        int unsigned span;
        int unsigned del;
        int unsigned pos;
        int unsigned sidx;
        bit [3:0]    acode;
        bit [3:0]    ncode;
        bit [27:0]   nlen;
        bit          has_next;
        bit          pre_gap;
        bit          late_op;
        bit [7:0]    c;

        rev = 1'($urandom_range(0, 1));
        off = $urandom_range(0, 12);
        if (off > cfg_anchor) off = cfg_anchor;
        at = cfg_anchor - off;

        // Saturate the query cursor with maximal soft clips.
        if ($urandom_range(0, 99) == 0) begin
            send_start(at, rev);
            repeat (17) send_op(CIG_S, '1);
            send_op(CIG_M, 28'(off + 1));
            repeat (3) send_base(pick_base());
            send_end();
            return;
        end

        v = $urandom_range(0, 99);
        if (v < 4) at = {1'b1, 31'($urandom)};
        else if (v < 8) at = cfg_anchor + $urandom_range(1, 5);

        clip    = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        m1      = $urandom_range(0, 1) ? off + 1 : off + 1 + $urandom_range(1, 5);
        pre_gap = ($urandom_range(0, 99) < 5);
        late_op = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 2))
            0:       acode = CIG_M;
            1:       acode = CIG_EQ;
            default: acode = CIG_X;
        endcase

        // Abandoned read: restarted by the next start beat.
        if ($urandom_range(0, 99) < 5) begin
            send_start($urandom, 1'($urandom));
            send_op(CIG_M, 28'($urandom_range(1, 20)));
            if ($urandom_range(0, 1)) send_base(pick_base());
        end

        send_start(at, rev);
        if ($urandom_range(0, 9) == 0) send_op(CIG_H, 28'($urandom_range(1, 5)));
        if (clip != 0) send_op(CIG_S, 28'(clip));
        if (pre_gap)
            send_op($urandom_range(0, 1) ? CIG_D : CIG_N, 28'($urandom_range(1, off + 3)));
        send_op(acode, 28'(m1));

        // Operation following the anchor op: matching or foreign indel, bad op, or none.
        span     = (cfg_alt_len > cfg_ref_len) ? cfg_alt_len - cfg_ref_len : 0;
        del      = (cfg_ref_len > cfg_alt_len) ? cfg_ref_len - cfg_alt_len : 0;
        ilen     = 0;
        has_next = 1'b1;
        v = $urandom_range(0, 99);
        if (v < 35) begin
            ncode = CIG_I;
            nlen  = (span != 0) ? 28'(span) : 28'($urandom_range(1, 4));
        end else if (v < 45) begin
            ncode = CIG_I;
            nlen  = 28'($urandom_range(1, 20));
        end else if (v < 70) begin
            ncode = CIG_D;
            nlen  = (del != 0) ? 28'(del) : 28'($urandom_range(1, 4));
        end else if (v < 75) begin
            ncode = CIG_D;
            nlen  = 28'($urandom_range(1, 20));
        end else if (v < 80) begin
            if ($urandom_range(0, 1)) begin
                ncode = CIG_X + 4'($urandom_range(1, 7));
                nlen  = 28'($urandom_range(1, 5));
            end else begin
                ncode = 4'($urandom_range(0, 8));
                nlen  = '0;
            end
        end else begin
            has_next = 1'b0;
        end
        if (has_next) begin
            send_op(ncode, nlen);
            if (ncode == CIG_I) ilen = 32'(nlen);
        end
        tail = $urandom_range(0, 6);
        if (tail != 0) send_op(CIG_M, 28'(tail));

        qlen = clip + m1 + ilen + tail;
        v = $urandom_range(0, 99);
        if (v < 10) nb = $urandom_range(0, qlen);
        else if (v < 15) nb = qlen + 2;
        else nb = qlen;
        for (int unsigned j = 0; j < nb; j++) seq = {seq, pick_base()};

        // Seed the anchor base and the insertion bases so calls land on all alleles.
        aidx = clip + off;
        if (!pre_gap && aidx < nb) begin
            v = $urandom_range(0, 99);
            if (v < 40) begin
                c = cfg_ref_first;
            end else if (v < 70) begin
                c = cfg_alt_first;
            end else if (v < 80) begin
                c = cfg_ref_first;
                if (c >= "A" && c <= "Z") c = c + 8'd32;
            end else begin
                c = pick_base();
            end
            seq[aidx] = c;
            if (span >= 1 && span <= MAX_INSERT) begin
                for (int unsigned k = 0; k < span; k++) begin
                    pos = aidx + 1 + k;
                    if (pos < nb) begin
                        sidx = rev ? span - 1 - k : k;
                        c = cfg_chars[8*sidx +: 8];
                        seq[pos] = rev ? comp_char(c) : c;
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    pos = aidx + 1 + $urandom_range(0, span - 1);
                    if (pos < nb) seq[pos] = seq[pos] ^ 8'h01;
                end
            end
        end

        for (int unsigned j = 0; j < nb; j++) begin
            send_base(seq[j]);
            // CIGAR beat after the bases started: must be ignored
            if (j == 0 && late_op) send_op(CIG_I, 28'($urandom_range(1, 4)));
        end
        send_end();
    endtask

    initial begin
        bit [63:0]   regv[CFG_INSERT_CHARS_HIGH+1];
        int          mark;
        int          saved;
        int unsigned kind;
        int unsigned n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset settings (anchor 0, one-base A/A).
        cfg_anchor    = '0;
        cfg_ref_len   = 8'd1;
        cfg_alt_len   = 8'd1;
        cfg_ref_first = "A";
        cfg_alt_first = "A";
        cfg_chars     = '0;
        // stray beats while no read is open
        send_end();
        send_base("C");
        send_op(CIG_M, 28'd1);
        // anchor on a lower-case base
        send_start('0, 1'b0);
        send_op(CIG_M, 28'd1);
        send_base("a");
        send_end();
        // unsupported operation of maximal length
        send_start('0, 1'b1);
        send_op(CIG_BAD, '1);
        send_end();
        // negative alignment start, no bases at all
        send_start('1, 1'b1);
        send_end();
        // restart mid-read, then anchor inside a deletion
        send_start(32'h7FFF_FFFF, 1'b0);
        send_start('0, 1'b0);
        send_op(CIG_D, 28'd1);
        send_op(CIG_M, '1);
        send_base(8'hFF);
        send_end();
        // CIGAR beat after the first base is ignored
        send_start('0, 1'b0);
        send_op(CIG_EQ, 28'd1);
        send_base(8'h00);
        send_op(CIG_I, 28'd1);
        send_end();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_quiet();
            idle_mode <= idle_mode_t'(ph % 4);
            if (ph == 4) hold_requests <= hold_requests + 1;

            case (ph)
                0: begin
                    regv[CFG_ANCHOR_POSITION]   = 64'h7FFF_FFFF;
                    regv[CFG_REF_LENGTH]        = 64'd255;
                    regv[CFG_ALT_LENGTH]        = 64'd255;
                    regv[CFG_REF_FIRST_BASE]    = 64'hFF;
                    regv[CFG_ALT_FIRST_BASE]    = 64'h00;
                    regv[CFG_INSERT_CHARS_LOW]  = '1;
                    regv[CFG_INSERT_CHARS_HIGH] = '1;
                end
                1: begin
                    regv[CFG_ANCHOR_POSITION]   = '0;
                    regv[CFG_REF_LENGTH]        = '0;
                    regv[CFG_ALT_LENGTH]        = '0;
                    regv[CFG_REF_FIRST_BASE]    = '0;
                    regv[CFG_ALT_FIRST_BASE]    = 64'hFF;
                    regv[CFG_INSERT_CHARS_LOW]  = '0;
                    regv[CFG_INSERT_CHARS_HIGH] = '0;
                end
                default: begin
                    kind = (ph < 8) ? ph - 2 : $urandom_range(0, 5);
                    regv[CFG_ANCHOR_POSITION] = $urandom_range(0, 3) == 0 ?
                                                64'($urandom) & 64'h7FFF_FFFF :
                                                64'($urandom_range(0, 5000));
                    regv[CFG_REF_FIRST_BASE] = 64'(pick_base());
                    regv[CFG_ALT_FIRST_BASE] = 64'(pick_base());
                    for (int w = 0; w < 8; w++) begin
                        regv[CFG_INSERT_CHARS_LOW][8*w +: 8]  = pick_base();
                        regv[CFG_INSERT_CHARS_HIGH][8*w +: 8] = pick_base();
                    end
                    case (kind)
                        0: begin   // single-base substitution
                            regv[CFG_REF_LENGTH] = 64'd1;
                            regv[CFG_ALT_LENGTH] = 64'd1;
                        end
                        1: begin   // insertion within the compare window
                            regv[CFG_REF_LENGTH] = 64'($urandom_range(1, 2));
                            regv[CFG_ALT_LENGTH] = regv[CFG_REF_LENGTH]
                                                   + 64'($urandom_range(1, 16));
                        end
                        2: begin   // insertion too long to compare
                            regv[CFG_REF_LENGTH] = 64'($urandom_range(1, 2));
                            regv[CFG_ALT_LENGTH] = regv[CFG_REF_LENGTH]
                                                   + 64'($urandom_range(17, 40));
                        end
                        3: begin   // deletion
                            regv[CFG_REF_LENGTH] = 64'($urandom_range(2, 20));
                            regv[CFG_ALT_LENGTH] =
                                64'($urandom_range(1, 32'(regv[CFG_REF_LENGTH]) - 1));
                        end
                        4: begin   // equal multi-base lengths
                            regv[CFG_REF_LENGTH] = 64'($urandom_range(2, 5));
                            regv[CFG_ALT_LENGTH] = regv[CFG_REF_LENGTH];
                        end
                        default: begin   // empty allele on one side or both
                            regv[CFG_REF_LENGTH] = $urandom_range(0, 1) ?
                                                   64'd0 : 64'($urandom_range(1, 4));
                            regv[CFG_ALT_LENGTH] = (regv[CFG_REF_LENGTH] == 64'd0) ?
                                                   64'($urandom_range(0, 4)) : 64'd0;
                        end
                    endcase
                end
            endcase

            for (int r = CFG_ANCHOR_POSITION; r <= CFG_INSERT_CHARS_HIGH; r++) begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_INDEX_W'(r);
                cfg_data  <= regv[r];
                sb.set_reg(CFG_INDEX_W'(r), regv[r]);
                @(posedge aclk);
            end
            cfg_we <= 1'b0;
            cfg_anchor    = regv[CFG_ANCHOR_POSITION][30:0];
            cfg_ref_len   = regv[CFG_REF_LENGTH][7:0];
            cfg_alt_len   = regv[CFG_ALT_LENGTH][7:0];
            cfg_ref_first = regv[CFG_REF_FIRST_BASE][7:0];
            cfg_alt_first = regv[CFG_ALT_FIRST_BASE][7:0];
            cfg_chars     = {regv[CFG_INSERT_CHARS_HIGH], regv[CFG_INSERT_CHARS_LOW]};

            mark = read_beats;
            while (read_beats - mark < READ_BEATS / NUM_PHASES) begin
                if ($urandom_range(0, 99) < 8) begin
                    // noise burst: any kind, any field value; not counted as read traffic
                    saved = read_beats;
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_beat(pac_op_t'($urandom_range(0, 3)),
                                  beat_data($urandom, 1'($urandom), 4'($urandom_range(0, 15)),
                                            ($urandom_range(0, 3) == 0) ? '0 : 28'($urandom),
                                            8'($urandom)));
                    read_beats = saved;
                end else begin
                    send_read();
                end
            end
        end

        wait_quiet();
        if (sb.errors == 0)
            $display("[pileup_allele_classifier] OK");
        else
            $display("[pileup_allele_classifier] ERROR");
        $finish;
    end

endmodule
